/* rtl/voxel_ray_traversal_3d_macros.svh */
// assertion helpers for the voxel traversal block
`ifndef VOXEL_RAY_TRAVERSAL_3D_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_3D_MACROS_SVH

// property that must hold when the antecedent is true, checked every edge
`define VRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property checked on the edge after the antecedent
`define VRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// shared types and constants of the voxel ray traversal block
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int GridBits       = 6;
  localparam int StepBits       = 12;
  localparam int StepLimitReset = 805;
  localparam int GridSizeReset  = 64;
  localparam int PosW           = 12;
  localparam int DirW           = 24;
  localparam int QW             = 32;
  localparam int CfgW           = 12;
  localparam int CfgIdxW        = 1;
  localparam int InDataW        = 152;
  localparam int OutDataW       = 48;

  localparam logic [CfgIdxW-1:0] CfgGridSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxSteps = 1'b1;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindTrace = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StDiv,
    StRead,
    StTest,
    StStep,
    StDone
  } vrt_state_e;

  typedef struct packed {
    logic            start;
    logic [DirW-1:0] mag;
  } vrt_div_req_t;

endpackage

/* rtl/vrt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_ram
// generic synchronous ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module vrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/vrt_recip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_recip
// radix-2 restoring divider computing 2^32 / mag, saturated to 32 bits
// ----------------------------------------------------------------------------
module vrt_recip (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vrt_pkg::vrt_div_req_t req_i,
  output logic                  busy_o,
  output logic [31:0]           quot_o
);
  import vrt_pkg::*;

  // dividend 2^32 has 33 bits, one quotient bit per cycle
  logic [DirW:0]   rem_q, rem_d;
  logic [32:0]     quo_q, quo_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [DirW-1:0] mag_q, mag_d;
  logic            busy_q, busy_d;
  logic [DirW+1:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    busy_d = busy_q;
    trial  = '0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = 33'h1_0000_0000;
      cnt_d  = 6'd33;
      mag_d  = req_i.mag;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[32]};
      quo_d = {quo_q[31:0], 1'b0};
      if (trial >= {2'b00, mag_q}) begin
        trial    = trial - {2'b00, mag_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DirW:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[32] ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

/* rtl/voxel_ray_traversal_3d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d
// 3d dda ray walker over a voxel store held in one synchronous ram
// ----------------------------------------------------------------------------
// channel  | dir | beat
// s_axis   | in  | one load or trace item (tuser = kind)
// m_axis   | out | one hit result per trace
// cfg      | in  | grid_size (0), max_steps (1)
// after reset the store is cleared one voxel a cycle, all 2^(3*GRID_BITS) voxels
// a load is written to the store as it is accepted; a trace first computes a
// reciprocal per axis in the serial divider, then walks in traversal steps
// of ram read, test and advance, paced by the serial divider and the registered ram read
// a result waits in the output register; a trace that ends meanwhile holds in done
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d #(
  parameter int GRID_BITS = vrt_pkg::GridBits,
  parameter int STEP_BITS = vrt_pkg::StepBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // load_x, load_y, load_z, load_occupied, load_color, start_x, start_y,
  // start_z, dir_x, dir_y, dir_z
  input  logic [vrt_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, hit_x, hit_y, hit_z, color_r, color_g, color_b
  output logic [vrt_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [vrt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vrt_pkg::CfgW-1:0]      cfg_wdata_i
);
  import vrt_pkg::*;
  `include "voxel_ray_traversal_3d_macros.svh"

  localparam int AddrW = 3 * GRID_BITS;
  localparam int Depth = 1 << AddrW;
  localparam int Edge  = 1 << GRID_BITS;

  // ---- config
  logic [6:0]           grid_size_q;
  logic [11:0]          max_steps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= 7'(GridSizeReset);
      max_steps_q <= 12'(StepLimitReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridSize: grid_size_q <= cfg_wdata_i[6:0];
        CfgMaxSteps: max_steps_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [8:0] gsz;
  assign gsz = ({2'b00, grid_size_q} > 9'(Edge)) ? 9'(Edge) : {2'b00, grid_size_q};

  logic [STEP_BITS-1:0] limit;
  always_comb begin
    if (STEP_BITS >= 12) begin
      limit = STEP_BITS'(max_steps_q);
    end else if ({20'd0, max_steps_q} > (32'(1) << STEP_BITS) - 32'd1) begin
      limit = '1;
    end else begin
      limit = STEP_BITS'(max_steps_q);
    end
  end

  // ---- input fields
  logic [5:0]  ld_x, ld_y, ld_z;
  logic        ld_occ;
  logic [23:0] ld_col;
  assign ld_x   = s_axis_tdata[5:0];
  assign ld_y   = s_axis_tdata[11:6];
  assign ld_z   = s_axis_tdata[17:12];
  assign ld_occ = s_axis_tdata[18];
  assign ld_col = s_axis_tdata[42:19];

  // ---- state
  vrt_state_e state_q, state_d;
  logic signed [PosW-1:0] pos_q [3];
  logic signed [PosW-1:0] pos_d [3];
  logic signed [DirW-1:0] dir_q [3];
  logic [QW-1:0]          nc_q [3];
  logic [QW-1:0]          nc_d [3];
  logic [QW-1:0]          cs_q [3];
  logic [1:0]             ax_q, ax_d;
  logic [STEP_BITS-1:0]   cnt_q, cnt_d;
  logic [AddrW:0]         clr_q, clr_d;
  logic                   divgo_q, divgo_d;
  logic                   ovld_q, ovld_d;
  logic [OutDataW-1:0]    odata_q, odata_d;
  logic [OutDataW-1:0]    res_q, res_d;
  logic                   in_acc;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // ---- divider
  vrt_div_req_t   dreq;
  logic           dbusy;
  logic [31:0]    dquot;
  logic [DirW-1:0] dmag;
  assign dmag       = dir_q[ax_q][DirW-1] ? DirW'(-dir_q[ax_q]) : dir_q[ax_q];
  assign dreq.start = divgo_q;
  assign dreq.mag   = dmag;

  vrt_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (dbusy),
    .quot_o (dquot)
  );

  // ---- ram
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [24:0]      wdata, rdata;
  logic             in_grid;

  assign in_grid = !pos_q[0][PosW-1] && !pos_q[1][PosW-1] && !pos_q[2][PosW-1] &&
                   (21'(pos_q[0]) < 21'(gsz)) && (21'(pos_q[1]) < 21'(gsz)) &&
                   (21'(pos_q[2]) < 21'(gsz));

  always_comb begin
    we    = 1'b0;
    waddr = clr_q[AddrW-1:0];
    wdata = '0;
    if (state_q == StClear) begin
      we = 1'b1;
    end else if (in_acc && s_axis_tuser == KindLoad) begin
      we    = (GRID_BITS >= 6) ||
              ((ld_x >> GRID_BITS) == 6'd0 && (ld_y >> GRID_BITS) == 6'd0 &&
               (ld_z >> GRID_BITS) == 6'd0);
      waddr = {GRID_BITS'(ld_z), GRID_BITS'(ld_y), GRID_BITS'(ld_x)};
      wdata = {ld_occ, ld_col};
    end
  end
  assign raddr = {GRID_BITS'(pos_q[2]), GRID_BITS'(pos_q[1]), GRID_BITS'(pos_q[0])};

  vrt_ram #(.Width(25), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---- next state
  logic [1:0] sel;
  always_comb begin
    if (nc_q[0] < nc_q[1]) begin
      sel = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
    end
  end

  logic signed [PosW-1:0] moved;
  logic signed [PosW-1:0] z_next;
  logic [QW:0]            ncsum;
  always_comb begin
    if (!dir_q[sel][DirW-1] && dir_q[sel] != '0) begin
      moved = (pos_q[sel] == 12'sd2047) ? pos_q[sel] : pos_q[sel] + 12'sd1;
    end else begin
      moved = (pos_q[sel] == 12'sh800) ? pos_q[sel] : pos_q[sel] - 12'sd1;
    end
    ncsum = {1'b0, nc_q[sel]} + {1'b0, cs_q[sel]};
  end

  // z after the step, whichever axis moves
  assign z_next = (sel == 2'd2) ? moved : pos_q[2];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == (AddrW+1)'(Depth - 1)) state_d = StIdle;
      StIdle: begin
        if (in_acc && s_axis_tuser == KindTrace) state_d = StDiv;
      end
      StDiv: begin
        if (!divgo_q && !dbusy && ax_q == 2'd2) begin
          state_d = (limit == '0) ? StDone : StRead;
        end
      end
      StRead: state_d = StTest;
      StTest: state_d = (in_grid && rdata[24]) ? StDone : StStep;
      StStep: begin
        if (z_next[PosW-1] == 1'b0 && 21'(z_next) >= 21'(gsz)) begin
          state_d = StDone;
        end else if (cnt_q + 1'b1 == limit) begin
          state_d = StDone;
        end else begin
          state_d = StRead;
        end
      end
      StDone: if (!ovld_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // ---- datapath
  always_comb begin
    pos_d   = pos_q;
    nc_d    = nc_q;
    ax_d    = ax_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    divgo_d = 1'b0;
    ovld_d  = ovld_q;
    odata_d = odata_q;
    res_d   = res_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    case (state_q)
      StClear: clr_d = clr_q + 1'b1;
      StIdle: begin
        if (in_acc && s_axis_tuser == KindTrace) begin
          pos_d[0] = s_axis_tdata[54:43];
          pos_d[1] = s_axis_tdata[66:55];
          pos_d[2] = s_axis_tdata[78:67];
          ax_d     = 2'd0;
          cnt_d    = '0;
          divgo_d  = 1'b1;
          res_d    = '0;
        end
      end
      StDiv: begin
        if (!divgo_q && !dbusy) begin
          nc_d[ax_q] = (dir_q[ax_q] == '0) ? '1 : dquot;
          if (ax_q != 2'd2) begin
            ax_d    = ax_q + 2'd1;
            divgo_d = 1'b1;
          end
        end
      end
      StTest: begin
        if (in_grid && rdata[24]) begin
          res_d = {5'd0, rdata[7:0], rdata[15:8], rdata[23:16], 6'(pos_q[2]),
                   6'(pos_q[1]), 6'(pos_q[0]), 1'b1};
        end
      end
      StStep: begin
        pos_d[sel] = moved;
        nc_d[sel]  = ncsum[QW] ? '1 : ncsum[QW-1:0];
        cnt_d      = cnt_q + 1'b1;
      end
      StDone: begin
        if (!ovld_q) begin
          ovld_d  = 1'b1;
          odata_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      divgo_q <= 1'b0;
      ovld_q  <= 1'b0;
      ax_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      divgo_q <= divgo_d;
      ovld_q  <= ovld_d;
      ax_q    <= ax_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    nc_q    <= nc_d;
    odata_q <= odata_d;
    res_q   <= res_d;
    if (state_q == StIdle && in_acc && s_axis_tuser == KindTrace) begin
      dir_q[0] <= s_axis_tdata[102:79];
      dir_q[1] <= s_axis_tdata[126:103];
      dir_q[2] <= s_axis_tdata[150:127];
    end
    // crossing step is the captured reciprocal; next crossing starts equal
    if (state_q == StDiv && !divgo_q && !dbusy) begin
      cs_q[ax_q] <= (dir_q[ax_q] == '0) ? '1 : dquot;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  `VRT_ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, state_q != StIdle, !s_axis_tready,
                   "input ready while busy")
  `VRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `VRT_ASSERT_IMPL(a_step_bound, clk_i, rst_ni, state_q == StStep, cnt_q < limit,
                   "step count beyond limit")

endmodule
